@@ src/stbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg
// shared types and constants of the sorted table binary search block
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  // signed probe bounds: low runs to depth, high down to minus one
  localparam int POS_W       = ADDR_W + 2;
  localparam int COUNT_W     = 11;
  localparam int INDEX_W     = 10;
  localparam int MATCH_W     = 10;
  localparam int DATA_W      = 32;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SEARCH = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [INDEX_W-1:0]       entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] search_key;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] match_position;
  } result_t;

  // table memory access, one write and one read port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

@@ src/stbs_table_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_table_ram
// table storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module stbs_table_ram (
  input  logic                    clk_i,
  input  stbs_pkg::ram_req_t      req_i,
  output logic [stbs_pkg::DATA_W-1:0] rdata_o
);
  import stbs_pkg::*;

  logic [DATA_W-1:0] mem [TABLE_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/stbs_search_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_search_ctrl
// transaction decode and probe sequencer, one table probe per clock
// ----------------------------------------------------------------------------
module stbs_search_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  stbs_pkg::item_t              item_i,
  input  logic [stbs_pkg::COUNT_W-1:0] entry_count_i,
  output logic                         busy_o,
  output stbs_pkg::ram_req_t           ram_req_o,
  input  logic [stbs_pkg::DATA_W-1:0]  ram_rdata_i,
  output logic                         result_valid_o,
  output stbs_pkg::result_t            result_o
);
  import stbs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_e;

  state_e                   state_q, state_d;
  logic signed [POS_W-1:0]  low_q, low_d;
  logic signed [POS_W-1:0]  high_q, high_d;
  logic [ADDR_W-1:0]        mid_q, mid_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic                     result_valid_q, result_valid_d;
  result_t                  result_q, result_d;

  logic                     accept;
  logic [ADDR_W:0]          count_sat;
  logic signed [POS_W-1:0]  mid_ext;
  logic signed [POS_W-1:0]  sum;
  logic                     key_lt, key_gt;

  assign accept = start_i && (state_q == ST_IDLE);

  // clamp the count to the table depth
  assign count_sat = (32'(entry_count_i) > 32'(TABLE_DEPTH)) ?
                     (ADDR_W+1)'(TABLE_DEPTH) : (ADDR_W+1)'(entry_count_i);

  assign mid_ext = $signed({2'b00, mid_q});
  assign key_lt  = key_q < $signed(ram_rdata_i);
  assign key_gt  = key_q > $signed(ram_rdata_i);

  always_comb begin
    state_d        = state_q;
    low_d          = low_q;
    high_d         = high_q;
    mid_d          = mid_q;
    key_d          = key_q;
    result_valid_d = 1'b0;
    result_d       = result_q;
    sum            = '0;

    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = ADDR_W'(item_i.entry_index);
    ram_req_o.wdata = item_i.entry_value;
    ram_req_o.re    = 1'b0;
    ram_req_o.raddr = mid_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.kind == KIND_WRITE) begin
            ram_req_o.we = 32'(item_i.entry_index) < 32'(TABLE_DEPTH);
          end else begin
            key_d  = item_i.search_key;
            low_d  = '0;
            high_d = $signed(POS_W'(count_sat)) - POS_W'(1);
            if (count_sat == '0) begin
              result_valid_d = 1'b1;
              result_d       = '0;
            end else begin
              sum             = high_d;
              mid_d           = sum[ADDR_W:1];
              ram_req_o.re    = 1'b1;
              ram_req_o.raddr = mid_d;
              state_d         = ST_SEARCH;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (!key_lt && !key_gt) begin
          result_valid_d = 1'b1;
          result_d.found = 1'b1;
          result_d.match_position = MATCH_W'(mid_q);
          state_d = ST_IDLE;
        end else begin
          if (key_lt) begin
            high_d = mid_ext - POS_W'(1);
          end else begin
            low_d = mid_ext + POS_W'(1);
          end
          if (low_d <= high_d) begin
            sum             = low_d + high_d;
            mid_d           = sum[ADDR_W:1];
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = mid_d;
          end else begin
            result_valid_d = 1'b1;
            result_d       = '0;
            state_d        = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q    <= low_d;
    high_q   <= high_d;
    mid_q    <= mid_d;
    key_q    <= key_d;
    result_q <= result_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

@@ src/sorted_table_binary_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// ascending table of signed entries with a binary search engine
// ----------------------------------------------------------------------------
// A transaction is taken when start_i is high and busy_o is low. A write
// transaction (kind = write) stores entry_value at entry_index, gives no
// result and leaves busy_o low. A search transaction probes the first
// entry_count entries (clamped to the depth), one table read per clock
// through the single read port of the table memory, with busy_o high; at
// most floor(log2(entry_count)) + 1 probes, 11 on a full table of 1024
// entries. The result strobe result_valid_o is high for exactly one cycle,
// the cycle in which busy_o drops again, so the next transaction can be
// taken alongside it; a search with entry_count zero answers in the next
// cycle. The receiver cannot stall results, so sample them on the strobe.
// The table has no reset; only entries already written may be probed. The
// user writes entry_count via the cfg channel only while idle, unchecked.
// ----------------------------------------------------------------------------
module sorted_table_binary_search (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // transaction command
  input  logic                         start_i,
  input  stbs_pkg::item_t              item_i,
  output logic                         busy_o,
  // result strobe
  output logic                         result_valid_o,
  output stbs_pkg::result_t            result_o,
  // entry_count register write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [stbs_pkg::COUNT_W-1:0] cfg_data_i
);
  import stbs_pkg::*;

  logic [COUNT_W-1:0] entry_count_q;
  ram_req_t           ram_req;
  logic [DATA_W-1:0]  ram_rdata;

  // the user writes the register only while idle; unchecked, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entry_count_q <= cfg_data_i;
    end
  end

  // probe sequencer and write decode
  stbs_search_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .item_i        (item_i),
    .entry_count_i (entry_count_q),
    .busy_o        (busy_o),
    .ram_req_o     (ram_req),
    .ram_rdata_i   (ram_rdata),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // table storage, read data registered, ready in the cycle after the probe address
  stbs_table_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rdata_o(ram_rdata)
  );

  // a result only shows once the sequencer is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result strobe while search still running");

  // not found always reports position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.found) |-> (result_o.match_position == '0))
    else $error("not-found result with nonzero position");

  // an empty search range answers at once with not found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (item_i.kind == KIND_SEARCH) && (entry_count_q == '0))
    |=> (result_valid_o && !result_o.found && !busy_o))
    else $error("empty search did not answer not-found in one cycle");

  // a write neither blocks the block nor makes a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (item_i.kind == KIND_WRITE))
    |=> (!busy_o && !result_valid_o))
    else $error("write transaction raised busy or a result");

endmodule

@@ bench/stbs_search_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_search_checker
// Watches the command, result and register channels of the table search
// block. It keeps its own copy of the table and of entry_count and computes
// the answer of every accepted search. Each result strobe is then compared,
// field by field, with the oldest search still waiting for its answer.
// ----------------------------------------------------------------------------
module stbs_search_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  stbs_pkg::item_t              item_i,
  input  logic                         result_valid_i,
  input  stbs_pkg::result_t            result_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [stbs_pkg::COUNT_W-1:0] cfg_data_i,
  output int                           error_count_o,
  output int                           lookups_open_o,
  output int                           lookups_done_o,
  output int                           hits_o
);
  import stbs_pkg::*;

  logic signed [DATA_W-1:0] table_copy [TABLE_DEPTH];
  logic [COUNT_W-1:0]       count_copy;
  result_t                  open_lookups [$];

  // probe sequence of a search over the leading entry_count entries
  function automatic result_t search_outcome(logic signed [DATA_W-1:0] key);
    int      lo;
    int      hi;
    int      mid;
    int      span;
    result_t answer;
    answer = '0;
    span   = (count_copy > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_copy);
    lo     = 0;
    hi     = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key < table_copy[mid]) begin
        hi = mid - 1;
      end else if (key > table_copy[mid]) begin
        lo = mid + 1;
      end else begin
        answer.found          = 1'b1;
        answer.match_position = mid[MATCH_W-1:0];
        return answer;
      end
    end
    return answer;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      count_copy = '0;
      open_lookups.delete();
      error_count_o  = 0;
      lookups_open_o = 0;
      lookups_done_o = 0;
      hits_o         = 0;
    end else begin
      // a result leaving at this edge belongs to an earlier search
      if (result_valid_i) begin
        if (open_lookups.size() == 0) begin
          error_count_o++;
          $display("%0t: result with no search waiting: expected none, actual found=%0b pos=%0d",
                   $time, result_i.found, result_i.match_position);
        end else begin
          want = open_lookups.pop_front();
          lookups_done_o++;
          if (want.found) hits_o++;
          if (result_i.found !== want.found) begin
            error_count_o++;
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, want.found, result_i.found);
          end
          if (result_i.match_position !== want.match_position) begin
            error_count_o++;
            $display("%0t: match_position mismatch: expected %0d, actual %0d",
                     $time, want.match_position, result_i.match_position);
          end
        end
      end
      // a search taken at this edge still sees the old entry_count
      if (start_i && !busy_i) begin
        if (item_i.kind == KIND_WRITE) begin
          table_copy[item_i.entry_index] = item_i.entry_value;
        end else begin
          open_lookups.push_back(search_outcome(item_i.search_key));
        end
      end
      if (cfg_valid_i && cfg_ready_i) count_copy = cfg_data_i;
      lookups_open_o = open_lookups.size();
    end
  end

endmodule

@@ bench/sorted_table_binary_search_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_test
// Drives table writes, entry_count updates and searches into the table
// search block. A short directed opening hits the value extremes and the
// empty table, then random phases each pick an entry_count, mostly refill
// the leading entries (sorted, dense with duplicates, or shuffled) and fire
// searches for present, neighboring, extreme and random keys. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_test;
  import stbs_pkg::*;

  localparam int RANDOM_ITEMS = 120;
  // a full table search makes at most 11 probes, so this covers the block going idle
  localparam int SETTLE_CYCLES = 16;

  typedef enum int {
    FILL_DENSE,
    FILL_SPREAD,
    FILL_SHUFFLED,
    FILL_FULL_SPAN
  } fill_style_e;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  item_t              item      = '0;
  logic               cfg_valid = 1'b0;
  logic [COUNT_W-1:0] cfg_data  = '0;
  logic               busy;
  logic               result_valid;
  result_t            result;
  logic               cfg_ready;

  int error_count;
  int lookups_open;
  int lookups_done;
  int hits;

  // what the stimulus has written, used only to pick useful keys
  logic signed [DATA_W-1:0] table_image [TABLE_DEPTH];
  bit gaps_on     = 1'b1;
  int gap_pct     = 30;
  int writes_sent = 0;
  int searches_sent = 0;
  int settings_used = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sorted_table_binary_search u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .item_i         (item),
    .busy_o         (busy),
    .result_valid_o (result_valid),
    .result_o       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  stbs_search_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item),
    .result_valid_i (result_valid),
    .result_i       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .error_count_o  (error_count),
    .lookups_open_o (lookups_open),
    .lookups_done_o (lookups_done),
    .hits_o         (hits)
  );

  // one command transaction: optional idle burst, then hold start until taken
  // called and returning at a rising edge; start stays high on return
  task automatic issue(item_t it);
    int gap;
    if (gaps_on && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    // busy only moves on rising edges, so the falling edge sees it settled
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (it.kind == KIND_WRITE) begin
      table_image[it.entry_index] = it.entry_value;
      writes_sent++;
    end else begin
      searches_sent++;
    end
  endtask

  task automatic write_entry(int idx, logic signed [DATA_W-1:0] value);
    item_t it;
    it.kind        = KIND_WRITE;
    it.entry_index = idx[INDEX_W-1:0];
    it.entry_value = value;
    it.search_key  = $urandom;   // ignored by a write, kept noisy
    issue(it);
  endtask

  task automatic search_for(logic signed [DATA_W-1:0] key);
    item_t it;
    it.kind        = KIND_SEARCH;
    it.entry_index = INDEX_W'($urandom);   // ignored by a search
    it.entry_value = $urandom;
    it.search_key  = key;
    issue(it);
  endtask

  // register write only once the block is idle and every answer is back
  task automatic set_entry_count(int n);
    start <= 1'b0;
    do @(negedge clk); while (busy || lookups_open != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n[COUNT_W-1:0];
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // rewrite entries 0..m-1 in one of several value patterns
  task automatic fill_table(int m, fill_style_e style);
    longint v;
    longint stride;
    int     i;
    v      = 0;
    stride = 64'd4294967295 / (m + 1);
    for (i = 0; i < m; i++) begin
      case (style)
        FILL_DENSE: begin
          // small steps, duplicates included
          if (i == 0) v = longint'(int'($urandom));
          else v = v + longint'($urandom_range(0, 3));
        end
        FILL_SHUFFLED: begin
          // no order at all, the probe walk still has to end
          v = longint'(int'($urandom));
        end
        default: begin
          if (i == 0) v = -64'sd2147483648 + longint'($urandom_range(0, stride));
          else v = v + longint'($urandom_range(0, stride));
          if (style == FILL_FULL_SPAN && i == 0) v = -64'sd2147483648;
          if (style == FILL_FULL_SPAN && i == m - 1) v = 64'sd2147483647;
        end
      endcase
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      write_entry(i, v[DATA_W-1:0]);
    end
  endtask

  // mostly keys that sit in the searched range, some near misses and extremes
  function automatic logic signed [DATA_W-1:0] pick_key(int span);
    int roll;
    int pos;
    roll = $urandom_range(99);
    pos  = (span > 0) ? $urandom_range(0, span - 1) : 0;
    if (span > 0 && roll < 50) return table_image[pos];
    if (span > 0 && roll < 70) return table_image[pos] + (roll[0] ? 1 : -1);
    if (roll < 82) begin
      case ($urandom_range(3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int n;
    int span;
    int searches;
    int phase_items;
    int roll;
    int j;
    int drain;
    bit refill;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed opening ----
    // empty search range straight after reset
    search_for(32'sh0000_0000);
    set_entry_count(3);
    write_entry(0, 32'sh8000_0000);
    write_entry(1, 32'sh0000_0000);
    write_entry(2, 32'sh7fff_ffff);
    search_for(32'sh8000_0000);
    search_for(32'sh0000_0000);
    search_for(32'sh7fff_ffff);
    search_for(-32'sd1);
    search_for(32'sd1);
    search_for(32'sh8000_0001);
    // top entry, all index bits set, outside the searched range
    write_entry(TABLE_DEPTH - 1, -32'sd1);
    search_for(-32'sd1);
    // single entry range
    set_entry_count(1);
    search_for(32'sh8000_0000);
    search_for(32'sh0000_0000);
    // largest entry lies just past the range
    set_entry_count(2);
    search_for(32'sh0000_0000);
    search_for(32'sh7fff_ffff);

    // ---- random phases ----
    // full table first, so any later entry_count is backed by written entries
    gap_pct = 25;
    set_entry_count(TABLE_DEPTH);
    fill_table(TABLE_DEPTH, FILL_FULL_SPAN);
    repeat (40) search_for(pick_key(TABLE_DEPTH));
    // count beyond the table depth clamps to the full table
    set_entry_count(2047);
    repeat (10) search_for(pick_key(TABLE_DEPTH));

    phase_items = 0;
    while (phase_items < RANDOM_ITEMS) begin
      // the closing stretch runs back to back
      gaps_on = (phase_items < RANDOM_ITEMS * 7 / 8);
      case ($urandom_range(2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 50;
      endcase
      roll   = $urandom_range(99);
      refill = 1'b1;
      if (roll < 6) begin
        // counts at and beyond the table depth
        case ($urandom_range(2))
          0:       n = TABLE_DEPTH;
          1:       n = 2047;
          default: n = $urandom_range(TABLE_DEPTH + 1, 2047);
        endcase
        refill = 1'b0;
      end else if (roll < 14) begin
        n = 0;
      end else begin
        n = $urandom_range(1, 40);
        // reuse whatever the prefix holds now and then
        refill = ($urandom_range(3) != 0);
      end
      set_entry_count(n);
      span = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
      if (refill && span > 0) begin
        fill_table(span, fill_style_e'($urandom_range(0, 3)));
        phase_items += span;
      end
      searches = $urandom_range(4, 24);
      for (j = 0; j < searches; j++) begin
        if ($urandom_range(9) == 0) write_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom);
        else search_for(pick_key(span));
        phase_items++;
      end
    end

    // ---- drain and verdict ----
    start <= 1'b0;
    @(negedge clk);
    for (drain = 0; drain < 1000 && (busy || lookups_open != 0); drain++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (lookups_open != 0) $display("%0t: %0d searches never answered", $time, lookups_open);
    $display("sent %0d table writes and %0d searches across %0d entry_count values",
             writes_sent, searches_sent, settings_used);
    $display("compared %0d search results, %0d of them hits", lookups_done, hits);
    if (error_count == 0 && lookups_open == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, many times the slowest legal run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
